// File: sv/cpd_pkg.sv
// Package for the command packet deframer.
// Holds the byte, word and index types, the frame constants and the framer phase encoding.
// No dependencies.
package cpd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [15:0] word_t;
  typedef logic [3:0] index_t;

  // Reset value of the start marker register, ASCII 'e'.
  localparam byte_t StartMarkerRst = 8'h65;
  // Whole frame length in bytes, as carried in the length field.
  localparam word_t FrameLen = 16'd8;
  // Byte positions inside a frame.
  localparam index_t IdxLenLow  = 4'd1;
  localparam index_t IdxLenHigh = 4'd2;
  localparam index_t IdxStop    = 4'd3;
  localparam index_t IdxLight   = 4'd4;
  localparam index_t IdxSeqLow  = 4'd5;
  localparam index_t IdxSeqHigh = 4'd6;
  localparam index_t IdxCsum    = 4'd7;
  // The checksum byte is this value minus the payload sum.
  localparam byte_t CsumBase = 8'hFF;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_LEN     = 2'd1,
    PH_COLLECT = 2'd2
  } phase_e;

endpackage

// File: sv/cpd_rx_if.sv
// Valid/ready channel that carries one received serial byte per item.
// Depends on cpd_pkg for the byte type.
interface cpd_rx_if
  import cpd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: sv/cpd_res_if.sv
// Valid/ready channel that carries one decoded command frame per item.
// Depends on cpd_pkg for the byte and word types.
interface cpd_res_if
  import cpd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t stop_request;
  byte_t light_mode;
  word_t sequence_res;
  logic  checksum_ok;
  logic  relay_enable;

  modport source (output valid, output stop_request, output light_mode,
                  output sequence_res, output checksum_ok, output relay_enable,
                  input ready);
  modport sink   (input valid, input stop_request, input light_mode,
                  input sequence_res, input checksum_ok, input relay_enable,
                  output ready);
endinterface

// File: sv/command_packet_deframer.sv
// Command packet deframer: an accepted byte goes through the input register;
// on the checksum byte the frame result then goes into the result register.
// Throughput is one byte per cycle; the input register only stalls while a
// result waits in the result register and the sink holds ready low.
// Reset (asynchronous, active low) returns to hunting for the start marker,
// opens the relay, clears the frame registers and loads the marker with 'e'.
module command_packet_deframer
  import cpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  byte_t      cfg_wdata_i,
  cpd_rx_if.sink     rx_i,
  cpd_res_if.source  res_o
);

  // Configuration: the byte value that opens a frame.
  byte_t start_marker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerRst;
    end else if (cfg_we_i) begin
      start_marker_q <= cfg_wdata_i;
    end
  end

  // Input register. A byte moves on into the framer whenever the result
  // register is free or is being emptied in the same cycle, so the framer
  // never has to hold a result it cannot deliver.
  logic  in_valid_q;
  byte_t in_byte_q;
  logic  advance;

  assign advance    = !res_o.valid || res_o.ready;
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // The framer consumes the registered byte in this cycle.
  logic step;
  assign step = in_valid_q && advance;

  // Framer state.
  phase_e phase_q, phase_d;
  index_t byte_index_q, byte_index_d;
  byte_t  length_low_q, length_low_d;
  byte_t  running_sum_q, running_sum_d;
  byte_t  stop_byte_q, stop_byte_d;
  byte_t  light_byte_q, light_byte_d;
  word_t  sequence_word_q, sequence_word_d;
  logic   relay_q, relay_d;

  // Checksum compare for the byte at hand; only meaningful on the checksum byte.
  logic csum_ok;
  assign csum_ok = ((CsumBase - running_sum_q) == in_byte_q);

  // Next state. Each phase follows the frame layout: marker, two length bytes,
  // stop, light, two sequence bytes and the checksum. Anything unexpected
  // (wrong length, an index outside the payload, the unused phase code)
  // drops back to hunting for the marker.
  always_comb begin
    phase_d         = phase_q;
    byte_index_d    = byte_index_q;
    length_low_d    = length_low_q;
    running_sum_d   = running_sum_q;
    stop_byte_d     = stop_byte_q;
    light_byte_d    = light_byte_q;
    sequence_word_d = sequence_word_q;
    relay_d         = relay_q;
    case (phase_q)
      PH_WAIT: begin
        if (in_byte_q == start_marker_q) begin
          byte_index_d  = IdxLenLow;
          running_sum_d = '0;
          phase_d       = PH_LEN;
        end
      end
      PH_LEN: begin
        if (byte_index_q == IdxLenLow) begin
          length_low_d = in_byte_q;
          byte_index_d = IdxLenHigh;
        end else if ({in_byte_q, length_low_q} != FrameLen) begin
          phase_d      = PH_WAIT;
          byte_index_d = '0;
        end else begin
          byte_index_d = IdxStop;
          phase_d      = PH_COLLECT;
        end
      end
      PH_COLLECT: begin
        if (byte_index_q < IdxStop || byte_index_q > IdxCsum) begin
          phase_d      = PH_WAIT;
          byte_index_d = '0;
        end else if (byte_index_q == IdxCsum) begin
          // A good checksum latches the relay drive: closed when no stop.
          if (csum_ok) begin
            relay_d = (stop_byte_q == '0);
          end
          phase_d      = PH_WAIT;
          byte_index_d = '0;
        end else begin
          case (byte_index_q)
            IdxStop:    stop_byte_d = in_byte_q;
            IdxLight:   light_byte_d = in_byte_q;
            IdxSeqLow:  sequence_word_d = {sequence_word_q[15:8], in_byte_q};
            IdxSeqHigh: sequence_word_d = {in_byte_q, sequence_word_q[7:0]};
            default:    sequence_word_d = sequence_word_q;
          endcase
          running_sum_d = running_sum_q + in_byte_q;
          byte_index_d  = byte_index_q + 4'd1;
        end
      end
      default: begin
        phase_d      = PH_WAIT;
        byte_index_d = '0;
      end
    endcase
  end

  // Outputs of the framer: a result is produced on the checksum byte.
  logic emit;

  always_comb begin
    emit = 1'b0;
    case (phase_q)
      PH_COLLECT: emit = (byte_index_q == IdxCsum);
      default:    emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_WAIT;
      byte_index_q    <= '0;
      length_low_q    <= '0;
      running_sum_q   <= '0;
      stop_byte_q     <= '0;
      light_byte_q    <= '0;
      sequence_word_q <= '0;
      relay_q         <= 1'b0;
    end else if (step) begin
      phase_q         <= phase_d;
      byte_index_q    <= byte_index_d;
      length_low_q    <= length_low_d;
      running_sum_q   <= running_sum_d;
      stop_byte_q     <= stop_byte_d;
      light_byte_q    <= light_byte_d;
      sequence_word_q <= sequence_word_d;
      relay_q         <= relay_d;
    end
  end

  // Result register. It loads whenever the framer steps, since a step only
  // happens when the register is free or is being read out.
  logic  res_valid_q;
  byte_t res_stop_q;
  byte_t res_light_q;
  word_t res_seq_q;
  logic  res_ok_q;
  logic  res_relay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_stop_q  <= stop_byte_q;
      res_light_q <= light_byte_q;
      res_seq_q   <= sequence_word_q;
      res_ok_q    <= csum_ok;
      res_relay_q <= relay_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.stop_request = res_stop_q;
  assign res_o.light_mode   = res_light_q;
  assign res_o.sequence_res = res_seq_q;
  assign res_o.checksum_ok  = res_ok_q;
  assign res_o.relay_enable = res_relay_q;

endmodule

// File: tb/command_packet_deframer_tb.sv
// Self-checking testbench for the command packet deframer.
// Needs cpd_pkg, the cpd_rx_if and cpd_res_if channels and command_packet_deframer.
// Random stimulus is checked against a predictor that runs on each accepted byte.
module command_packet_deframer_tb;
  import cpd_pkg::*;

  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 11;
  // A byte clears the block through the input and result registers once the result
  // side is free; this settling time comes before a marker write or the final check.
  localparam int SettleCycles = 4;
  localparam int LongHold     = 300;
  localparam int IdlePercent  = 14;
  localparam int PhaseBytes   = 350;
  localparam int CycleLimit   = 200000;
  localparam int DrainLimit   = 5000;

  // One decoded frame, as the result channel is expected to present it.
  typedef struct {
    byte_t stop_request;
    byte_t light_mode;
    word_t sequence_res;
    logic  checksum_ok;
    logic  relay_enable;
  } frame_res_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  cfg_we_i    = 1'b0;
  byte_t cfg_wdata_i = '0;

  // The channel inputs are driven through these variables so that they have a
  // known value from time zero on.
  logic  rx_valid  = 1'b0;
  byte_t rx_data   = '0;
  logic  res_ready = 1'b0;

  cpd_rx_if  rx_if ();
  cpd_res_if res_if ();

  assign rx_if.valid   = rx_valid;
  assign rx_if.rx_byte = rx_data;
  assign res_if.ready  = res_ready;

  command_packet_deframer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Bytes waiting to be offered, and the frames the block still owes us.
  byte_t      rx_byte_q[$];
  frame_res_t exp_frame_q[$];

  // The driver sets this when it puts a byte on the channel and clears it when
  // the byte is accepted. The queue and this flag change together, so other
  // processes always see a consistent picture of what is still in flight.
  bit          byte_held = 1'b0;
  bit          gaps_on   = 1'b1;
  int unsigned hold_reqs = 0;

  int unsigned cycle_count     = 0;
  int unsigned error_count     = 0;
  int unsigned items_queued    = 0;
  int unsigned bytes_accepted  = 0;
  int unsigned frames_checked  = 0;
  int unsigned frames_bad_csum = 0;
  int unsigned marker_settings = 1;

  // Predictor state: a copy of the start marker register and of the framer.
  byte_t  cur_marker = StartMarkerRst;
  phase_e fr_phase   = PH_WAIT;
  index_t fr_index   = '0;
  byte_t  len_low    = '0;
  byte_t  csum_acc   = '0;
  byte_t  stop_q     = '0;
  byte_t  light_q    = '0;
  word_t  seq_q      = '0;
  logic   relay_q    = 1'b0;

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0d] MISMATCH %s: got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Advances the framer copy by one accepted byte. When the byte closes a
  // frame, the frame that the block must report is queued.
  function automatic void predict_byte(byte_t b);
    frame_res_t fr;
    case (fr_phase)
      PH_WAIT: begin
        if (b == cur_marker) begin
          fr_index = IdxLenLow;
          csum_acc = '0;
          fr_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (fr_index == IdxLenLow) begin
          len_low  = b;
          fr_index = IdxLenHigh;
        end else if ({b, len_low} != FrameLen) begin
          // A wrong length drops the frame and hunting starts on the next byte.
          fr_phase = PH_WAIT;
          fr_index = '0;
        end else begin
          fr_index = IdxStop;
          fr_phase = PH_COLLECT;
        end
      end
      PH_COLLECT: begin
        if (fr_index > IdxCsum || fr_index < IdxStop) begin
          fr_phase = PH_WAIT;
          fr_index = '0;
        end else if (fr_index != IdxCsum) begin
          case (fr_index)
            IdxStop:    stop_q = b;
            IdxLight:   light_q = b;
            IdxSeqLow:  seq_q[7:0] = b;
            IdxSeqHigh: seq_q[15:8] = b;
            default: ;
          endcase
          csum_acc = csum_acc + b;
          fr_index = fr_index + 4'd1;
        end else begin
          fr.checksum_ok = (byte_t'(CsumBase - csum_acc) == b);
          // Only a frame with a good checksum moves the relay; a bad one
          // reports the relay as it was.
          if (fr.checksum_ok) begin
            relay_q = (stop_q == '0);
          end
          fr.stop_request = stop_q;
          fr.light_mode   = light_q;
          fr.sequence_res = seq_q;
          fr.relay_enable = relay_q;
          exp_frame_q.push_back(fr);
          fr_phase = PH_WAIT;
          fr_index = '0;
        end
      end
      default: begin
        fr_phase = PH_WAIT;
        fr_index = '0;
      end
    endcase
  endfunction

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  // A zero stop byte closes the relay, so it is drawn often enough to keep
  // the relay toggling.
  function automatic byte_t rand_stop();
    if ($urandom_range(0, 99) < 30) begin
      return '0;
    end
    return rand_byte();
  endfunction

  task automatic queue_byte(byte_t b);
    rx_byte_q.push_back(b);
    items_queued++;
  endtask

  // Queues a complete frame of FrameLen bytes under the current marker. With
  // corrupt set, the checksum byte is wrong by a nonzero amount.
  task automatic push_frame(byte_t stop, byte_t light, word_t seq, bit corrupt);
    byte_t csum;
    csum = CsumBase - (stop + light + seq[7:0] + seq[15:8]);
    if (corrupt) begin
      csum = csum ^ byte_t'($urandom_range(1, 255));
    end
    queue_byte(cur_marker);
    queue_byte(FrameLen[7:0]);
    queue_byte(FrameLen[15:8]);
    queue_byte(stop);
    queue_byte(light);
    queue_byte(seq[7:0]);
    queue_byte(seq[15:8]);
    queue_byte(csum);
  endtask

  // Returns once every queued byte has been taken and every frame has come
  // back, then waits SettleCycles for a byte that produces no result.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (rx_byte_q.size() != 0 || byte_held || exp_frame_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_marker(byte_t value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cur_marker = value;
    marker_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, mixed with wrong lengths,
  // frames cut short and bursts of line noise.
  task automatic random_traffic(int unsigned n_bytes);
    int unsigned start_count;
    int unsigned pick;
    int unsigned k;
    byte_t       lo;
    byte_t       hi;
    start_count = items_queued;
    while (items_queued - start_count < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        push_frame(rand_stop(), rand_byte(), word_t'($urandom_range(0, 65535)),
                   $urandom_range(0, 99) < 15);
      end else if (pick < 80) begin
        lo = $urandom_range(0, 1) ? FrameLen[7:0] : rand_byte();
        hi = rand_byte();
        if ({hi, lo} == FrameLen) begin
          hi = 8'h01;
        end
        queue_byte(cur_marker);
        queue_byte(lo);
        queue_byte(hi);
      end else if (pick < 90) begin
        queue_byte(cur_marker);
        queue_byte(FrameLen[7:0]);
        queue_byte(FrameLen[15:8]);
        k = $urandom_range(0, 4);
        repeat (k) queue_byte(rand_byte());
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) queue_byte(rand_byte());
      end
    end
  endtask

  // Driver: offers the next queued byte, holds it until it is taken, and now
  // and then leaves a gap between bytes. Every accepted byte feeds the
  // predictor at the same edge at which the block takes it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && rx_if.ready) begin
        predict_byte(rx_data);
        bytes_accepted++;
        byte_held = 1'b0;
      end
      if (!byte_held) begin
        if (rx_byte_q.size() != 0 &&
            !(gaps_on && $urandom_range(0, 99) < IdlePercent)) begin
          rx_data   <= rx_byte_q.pop_front();
          rx_valid  <= 1'b1;
          byte_held = 1'b1;
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each delivered frame against the oldest expected one and
  // drives ready. A long hold-off, counted here, is started whenever the
  // stimulus asks for one.
  always @(posedge clk_i) begin : result_monitor
    frame_res_t  want;
    int unsigned hold_cycles;
    int unsigned hold_served;
    if (!rst_ni) begin
      res_ready <= 1'b0;
      hold_cycles = 0;
      hold_served = 0;
    end else begin
      if (res_if.valid && res_ready) begin
        if (exp_frame_q.size() == 0) begin
          flag_mismatch("frame with none pending, sequence", res_if.sequence_res, 0);
        end else begin
          want = exp_frame_q.pop_front();
          frames_checked++;
          if (!want.checksum_ok) begin
            frames_bad_csum++;
          end
          if (res_if.stop_request !== want.stop_request) begin
            flag_mismatch("stop_request", res_if.stop_request, want.stop_request);
          end
          if (res_if.light_mode !== want.light_mode) begin
            flag_mismatch("light_mode", res_if.light_mode, want.light_mode);
          end
          if (res_if.sequence_res !== want.sequence_res) begin
            flag_mismatch("sequence_res", res_if.sequence_res, want.sequence_res);
          end
          if (res_if.checksum_ok !== want.checksum_ok) begin
            flag_mismatch("checksum_ok", res_if.checksum_ok, want.checksum_ok);
          end
          if (res_if.relay_enable !== want.relay_enable) begin
            flag_mismatch("relay_enable", res_if.relay_enable, want.relay_enable);
          end
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        res_ready <= 1'b0;
      end else if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        hold_cycles = LongHold;
        res_ready <= 1'b0;
      end else begin
        res_ready <= !(gaps_on && $urandom_range(0, 99) < IdlePercent);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d frames outstanding",
               cycle_count, exp_frame_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned drain;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed frames under the marker that reset loads. The first frame has
    // all-zero fields, so it closes the relay and carries the largest checksum.
    push_frame(8'h00, 8'h00, 16'h0000, 1'b0);
    // All-ones fields with a good checksum: a nonzero stop opens the relay.
    push_frame(8'hFF, 8'hFF, 16'hFFFF, 1'b0);
    // A length of 0x0108 is dropped even though its low byte is right.
    queue_byte(cur_marker);
    queue_byte(FrameLen[7:0]);
    queue_byte(8'h01);
    // A zero stop with a bad checksum must leave the relay open.
    push_frame(8'h00, 8'h5A, 16'h1234, 1'b1);

    // Random phases, each under a newly written start marker. The marker written
    // first is the reset value, then both extremes and two random values.
    set_marker(StartMarkerRst);
    random_traffic(PhaseBytes);

    // With the zero marker the receiver holds off for a long stretch while
    // bytes keep coming, so the block backs up and stalls its input.
    set_marker(8'h00);
    hold_reqs++;
    random_traffic(PhaseBytes);

    // The all-ones marker phase runs with no gaps on either side.
    set_marker(8'hFF);
    gaps_on = 1'b0;
    random_traffic(PhaseBytes);
    wait_idle();
    gaps_on = 1'b1;

    // In this phase the sender stops halfway until all frames are back.
    set_marker(rand_byte());
    random_traffic(PhaseBytes / 2);
    wait_idle();
    random_traffic(PhaseBytes / 2);

    set_marker(rand_byte());
    random_traffic(PhaseBytes);

    // Let everything drain, with a bound so that leftover frames get reported.
    drain = 0;
    while ((rx_byte_q.size() != 0 || byte_held || exp_frame_q.size() != 0) &&
           drain < DrainLimit) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (exp_frame_q.size() != 0) begin
      flag_mismatch("frames never delivered", exp_frame_q.size(), 0);
    end

    $display("Covered %0d bytes under %0d start marker settings, including a long stall.",
             bytes_accepted, marker_settings);
    $display("Checked %0d frames, %0d of them with a bad checksum; %0d mismatches.",
             frames_checked, frames_bad_csum, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
